[rtl/core/fswcs_pkg.sv]
// shared types and constants for the focus stack window contrast select unit
package fswcs_pkg;

  localparam int LANES       = 4;
  localparam int MAX_IMAGES  = 4;
  localparam int PIX_W       = 24;
  localparam int GREY_W      = 10;
  localparam int IDX_W       = 2;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_DATA_W   = LANES * PIX_W;
  localparam int OUT_DATA_W  = 16;

  localparam logic [GREY_W-1:0] GREY_TOP = 10'd765;

  // active lane count never exceeds the images supported or the pixel lanes
  localparam int ACTIVE_CAP  = (MAX_IMAGES < LANES) ? MAX_IMAGES : LANES;

  localparam logic [COUNT_W-1:0] IMAGE_COUNT_RST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COUNT  = 8'd0,
    CFG_PIXEL_FORMAT = 8'd1
  } cfg_reg_t;

  // window summary handed from the lane side to the merge stage
  typedef struct packed {
    logic                 load;
    logic                 seen;
    logic [COUNT_W-1:0]   active;
  } win_info_t;

  typedef logic [GREY_W-1:0] grey_t;

endpackage

[rtl/core/focus_stack_window_contrast_select_unit.sv]
// top level: configuration registers, image lanes and contrast merge
// result path: the last word of a window loads the lane contrast and s1_valid registers;
//   the merge then registers the result word and raises out_tvalid when the output advances
// throughput: one window position per cycle, set by the min/max update
//   in each lane; input stalls only while a finished window waits behind a held result word
// reset: synchronous active-low rst_n resets lane min/max, window state and valid flags;
//   image_count returns to 4 and pixel_format to 0
module focus_stack_window_contrast_select_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pix_0 [23:0], pix_1 [47:24], pix_2 [71:48], pix_3 [95:72]
  input  logic [fswcs_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_window [0]
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // best_image [1:0], best_contrast [11:2], zero [15:12]
  output logic [fswcs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // found [0]
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fswcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fswcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [fswcs_pkg::COUNT_W-1:0] image_count_r, image_count_nxt;
  logic                          pixel_format_r, pixel_format_nxt;
  logic                          seen_r, seen_nxt;
  logic                          in_acc;
  logic                          fold;
  logic                          close;
  logic                          load_ready;
  logic [fswcs_pkg::COUNT_W-1:0] active_c;
  fswcs_pkg::win_info_t          win;
  fswcs_pkg::grey_t              contrast [fswcs_pkg::LANES];
  logic                          found_r;
  logic [fswcs_pkg::IDX_W-1:0]   best_image_r;
  fswcs_pkg::grey_t              best_contrast_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    image_count_nxt  = image_count_r;
    pixel_format_nxt = pixel_format_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        fswcs_pkg::CFG_IMAGE_COUNT:  image_count_nxt  = cfg_data[fswcs_pkg::COUNT_W-1:0];
        fswcs_pkg::CFG_PIXEL_FORMAT: pixel_format_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_count_r  <= fswcs_pkg::IMAGE_COUNT_RST;
      pixel_format_r <= 1'b0;
    end else begin
      image_count_r  <= image_count_nxt;
      pixel_format_r <= pixel_format_nxt;
    end
  end

  assign in_tready = load_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign fold      = in_acc && in_tuser;
  assign close     = in_acc && in_tlast;

  always_comb begin
    if (int'(image_count_r) > fswcs_pkg::ACTIVE_CAP) begin
      active_c = fswcs_pkg::COUNT_W'(fswcs_pkg::ACTIVE_CAP);
    end else begin
      active_c = image_count_r;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (close) begin
      seen_nxt = 1'b0;
    end else if (fold) begin
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign win.load   = close;
  assign win.seen   = seen_r || fold;
  assign win.active = active_c;

  for (genvar k = 0; k < fswcs_pkg::LANES; k++) begin : g_lane
    fswcs_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .pix          (in_tdata[k*fswcs_pkg::PIX_W +: fswcs_pkg::PIX_W]),
      .pixel_format (pixel_format_r),
      .fold         (fold),
      .close        (close),
      .contrast_r   (contrast[k])
    );
  end

  fswcs_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .win             (win),
    .contrast        (contrast),
    .load_ready      (load_ready),
    .out_valid_r     (out_tvalid),
    .out_ready       (out_tready),
    .found_r         (found_r),
    .best_image_r    (best_image_r),
    .best_contrast_r (best_contrast_r)
  );

  assign out_tdata = {4'b0000, best_contrast_r, best_image_r};
  assign out_tuser = found_r;

endmodule

[rtl/core/fswcs_lane.sv]
// one image lane: grey conversion, running min and max, contrast on window close
module fswcs_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fswcs_pkg::PIX_W-1:0]   pix,
  input  logic                          pixel_format,
  input  logic                          fold,
  input  logic                          close,
  output fswcs_pkg::grey_t              contrast_r
);

  fswcs_pkg::grey_t min_r, min_nxt;
  fswcs_pkg::grey_t max_r, max_nxt;
  fswcs_pkg::grey_t grey;
  fswcs_pkg::grey_t upd_min;
  fswcs_pkg::grey_t upd_max;
  logic [7:0] r_c, g_c, b_c;

  assign r_c = pix[7:0];
  assign g_c = pix[15:8];
  assign b_c = pix[23:16];

  always_comb begin
    if (pixel_format) begin
      grey = {2'b00, r_c} + {1'b0, r_c, 1'b0};
    end else begin
      grey = {2'b00, r_c} + {2'b00, g_c} + {2'b00, b_c};
    end
  end

  always_comb begin
    upd_min = min_r;
    upd_max = max_r;
    if (fold) begin
      if (grey < min_r) upd_min = grey;
      if (grey > max_r) upd_max = grey;
    end
  end

  always_comb begin
    if (close) begin
      min_nxt = fswcs_pkg::GREY_TOP;
      max_nxt = '0;
    end else begin
      min_nxt = upd_min;
      max_nxt = upd_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= fswcs_pkg::GREY_TOP;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // only meaningful when the lane saw an in-bounds position
  always_ff @(posedge clk) begin
    if (close) begin
      contrast_r <= upd_max - upd_min;
    end
  end

endmodule

[rtl/core/fswcs_merge.sv]
// merge stage: picks the active lane with top contrast and drives the result word
module fswcs_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fswcs_pkg::win_info_t        win,
  input  fswcs_pkg::grey_t            contrast [fswcs_pkg::LANES],
  output logic                        load_ready,
  output logic                        out_valid_r,
  input  logic                        out_ready,
  output logic                        found_r,
  output logic [fswcs_pkg::IDX_W-1:0] best_image_r,
  output fswcs_pkg::grey_t            best_contrast_r
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          seen_r;
  logic [fswcs_pkg::COUNT_W-1:0] active_r;
  logic                          out_valid_nxt;
  logic                          out_adv;
  logic                          found_c;
  logic [fswcs_pkg::IDX_W-1:0]   best_idx_c;
  fswcs_pkg::grey_t              best_val_c;

  assign out_adv    = !out_valid_r || out_ready;
  assign load_ready = !s1_valid_r || out_adv;

  always_comb begin
    found_c    = 1'b0;
    best_idx_c = '0;
    best_val_c = '0;
    if (seen_r) begin
      for (int i = 0; i < fswcs_pkg::LANES; i++) begin
        if (i < int'(active_r)) begin
          if (!found_c || contrast[i] > best_val_c) begin
            found_c    = 1'b1;
            best_idx_c = fswcs_pkg::IDX_W'(i);
            best_val_c = contrast[i];
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (win.load) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win.load) begin
      seen_r   <= win.seen;
      active_r <= win.active;
    end
    if (out_adv && s1_valid_r) begin
      found_r         <= found_c;
      best_image_r    <= best_idx_c;
      best_contrast_r <= best_val_c;
    end
  end

endmodule
